// ===== hw/rtl/pgg_pkg.sv =====
// ---------------------------------------------------------------------------
// pgg_pkg
// Types and constants shared by the grid gravity step block.
// ---------------------------------------------------------------------------
package pgg_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int CELL_W     = 2 * SIDE_W;
    localparam int CELLS      = MAX_SIDE * MAX_SIDE;
    localparam int MASS_W     = 48;
    localparam int SUM_W      = 64;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMMIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        mass;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        new_pos_x;
        logic [31:0]        new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               cell_moved;
        logic               saturated;
    } out_item_t;

    // divider control and status
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

endpackage

// ===== hw/rtl/particle_grid_gravity_step.sv =====
// ---------------------------------------------------------------------------
// particle_grid_gravity_step
// Grid gravity step on a unit torus with live and snapshot cell grids.
// ---------------------------------------------------------------------------
// an advance uses the one shared 64-bit divider (up to three divisions for each of
// the nine cells around and including the item's cell). after reset a clearing
// pass zeroes all 4096 cells of both grids; busy stays high meanwhile. one item
// at a time; the result strobe lasts one cycle, no stall.
module particle_grid_gravity_step
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pgg_pkg::in_item_t    in_item,
    output logic                 done,
    output pgg_pkg::out_item_t   out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CW = pgg_pkg::CELL_W;
    localparam int SW = pgg_pkg::SIDE_W;

    localparam logic [4:0] ST_CLEAR   = 5'd0;
    localparam logic [4:0] ST_IDLE    = 5'd1;
    localparam logic [4:0] ST_CELL    = 5'd2;
    localparam logic [4:0] ST_RMW_RD  = 5'd3;
    localparam logic [4:0] ST_RMW_WAIT= 5'd4;
    localparam logic [4:0] ST_RMW_WR  = 5'd5;
    localparam logic [4:0] ST_COPY    = 5'd6;
    localparam logic [4:0] ST_NB_RD   = 5'd7;
    localparam logic [4:0] ST_NB_WAIT = 5'd8;
    localparam logic [4:0] ST_DIVX    = 5'd9;
    localparam logic [4:0] ST_DIVY    = 5'd10;
    localparam logic [4:0] ST_DIST    = 5'd11;
    localparam logic [4:0] ST_D2      = 5'd12;
    localparam logic [4:0] ST_MG0     = 5'd13;
    localparam logic [4:0] ST_MG1     = 5'd14;
    localparam logic [4:0] ST_MAG     = 5'd15;
    localparam logic [4:0] ST_FX0     = 5'd16;
    localparam logic [4:0] ST_FX1     = 5'd17;
    localparam logic [4:0] ST_FY0     = 5'd18;
    localparam logic [4:0] ST_FY1     = 5'd19;
    localparam logic [4:0] ST_UPD0    = 5'd20;
    localparam logic [4:0] ST_UPD1    = 5'd21;
    localparam logic [4:0] ST_UPD2    = 5'd22;
    localparam logic [4:0] ST_DONE    = 5'd23;
    localparam logic [4:0] ST_DIVW    = 5'd24;

    // grid memories
    logic [pgg_pkg::MASS_W-1:0] live_m  [pgg_pkg::CELLS];
    logic [pgg_pkg::SUM_W-1:0]  live_x  [pgg_pkg::CELLS];
    logic [pgg_pkg::SUM_W-1:0]  live_y  [pgg_pkg::CELLS];
    logic [pgg_pkg::MASS_W-1:0] snap_m  [pgg_pkg::CELLS];
    logic [pgg_pkg::SUM_W-1:0]  snap_x  [pgg_pkg::CELLS];
    logic [pgg_pkg::SUM_W-1:0]  snap_y  [pgg_pkg::CELLS];

    logic [pgg_pkg::MASS_W-1:0] lm_rd, sm_rd;
    logic [pgg_pkg::SUM_W-1:0]  lx_rd, ly_rd, sx_rd, sy_rd;
    logic [CW-1:0] live_raddr, snap_raddr, live_waddr, snap_waddr;
    logic          live_we, snap_we;
    logic [pgg_pkg::MASS_W-1:0] lm_wd, sm_wd;
    logic [pgg_pkg::SUM_W-1:0]  lx_wd, ly_wd, sx_wd, sy_wd;

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_m[live_waddr] <= lm_wd;
            live_x[live_waddr] <= lx_wd;
            live_y[live_waddr] <= ly_wd;
        end
        lm_rd <= live_m[live_raddr];
        lx_rd <= live_x[live_raddr];
        ly_rd <= live_y[live_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (snap_we)
        begin
            snap_m[snap_waddr] <= sm_wd;
            snap_x[snap_waddr] <= sx_wd;
            snap_y[snap_waddr] <= sy_wd;
        end
        sm_rd <= snap_m[snap_raddr];
        sx_rd <= snap_x[snap_raddr];
        sy_rd <= snap_y[snap_raddr];
    end

    // configuration
    logic [6:0]  side_cfg_reg;
    logic [31:0] grav_reg;
    logic [31:0] mind_reg;
    logic [6:0]  side;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg <= 7'd64;
            grav_reg     <= 32'd0;
            mind_reg     <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pgg_pkg::REG_GRID_SIDE:  side_cfg_reg <= cfg_data[6:0];
                pgg_pkg::REG_GRAV_CONST: grav_reg     <= cfg_data;
                pgg_pkg::REG_MIN_DIST:   mind_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (side_cfg_reg == 7'd0)
            side = 7'd1;
        else if (side_cfg_reg > 7'(pgg_pkg::MAX_SIDE))
            side = 7'(pgg_pkg::MAX_SIDE);
        else
            side = side_cfg_reg;
    end

    // divider
    pgg_pkg::div_req_t div_req;
    pgg_pkg::div_rsp_t div_rsp;

    pgg_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer registers
    logic [4:0]  state_reg, state_next;
    logic [CW:0] cnt_reg, cnt_next;
    logic [3:0]  nb_reg, nb_next;
    logic        sub_phase_reg, sub_phase_next;
    pgg_pkg::in_item_t item_reg, item_next;
    logic [SW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [SW-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [63:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [47:0] cm_reg, cm_next;
    logic [63:0] csx_reg, csx_next, csy_reg, csy_next;
    logic signed [33:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0] adx_reg, adx_next, ady_reg, ady_next;
    logic [63:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [63:0] mag_reg, mag_next;
    logic [31:0] npx_reg, npx_next, npy_reg, npy_next;
    logic signed [31:0] nvx_reg, nvx_next, nvy_reg, nvy_next;
    logic        sat_reg, sat_next, moved_reg, moved_next;
    logic        done_reg, done_next;
    pgg_pkg::out_item_t out_reg, out_next;

    // cell of a position
    function automatic logic [SW-1:0] cell_of(input logic [31:0] p, input logic [6:0] s);
        logic [38:0] prod;
        prod = {7'd0, p} * {32'd0, s};
        return prod[32 +: SW];
    endfunction

    function automatic logic signed [63:0] clamp31(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        else if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    logic [SW-1:0] nbx, nby;
    logic [1:0]    nbi, nbj;
    logic [63:0]   mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [63:0]   msum;
    logic [64:0]   asum;
    logic [pgg_pkg::MASS_W:0] masum;
    logic signed [63:0] tmpa, tmpb, tmpv;
    logic [63:0]   mpx, mpy;

    always_comb
    begin
        // neighbor number to row and column offset codes
        case (nb_reg)
            4'd1:    begin nbi = 2'd0; nbj = 2'd1; end
            4'd2:    begin nbi = 2'd0; nbj = 2'd2; end
            4'd3:    begin nbi = 2'd1; nbj = 2'd0; end
            4'd4:    begin nbi = 2'd1; nbj = 2'd1; end
            4'd5:    begin nbi = 2'd1; nbj = 2'd2; end
            4'd6:    begin nbi = 2'd2; nbj = 2'd0; end
            4'd7:    begin nbi = 2'd2; nbj = 2'd1; end
            4'd8:    begin nbi = 2'd2; nbj = 2'd2; end
            default: begin nbi = 2'd0; nbj = 2'd0; end
        endcase
        case (nbi)
            2'd1: nbx = (7'({1'b0, cx_reg}) + 7'd1 == side) ? '0 : cx_reg + SW'(1);
            2'd2: nbx = (cx_reg == '0) ? SW'(side - 7'd1) : cx_reg - SW'(1);
            default: nbx = cx_reg;
        endcase
        case (nbj)
            2'd1: nby = (7'({1'b0, cy_reg}) + 7'd1 == side) ? '0 : cy_reg + SW'(1);
            2'd2: nby = (cy_reg == '0) ? SW'(side - 7'd1) : cy_reg - SW'(1);
            default: nby = cy_reg;
        endcase
    end

    // shared 32x32 multiplier
    assign mul_p = {32'd0, mul_a[31:0]} * {32'd0, mul_b[31:0]};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        nb_next        = nb_reg;
        sub_phase_next = sub_phase_reg;
        item_next      = item_reg;
        cx_next = cx_reg; cy_next = cy_reg; nx_next = nx_reg; ny_next = ny_reg;
        ax_next = ax_reg; ay_next = ay_reg;
        cm_next = cm_reg; csx_next = csx_reg; csy_next = csy_reg;
        dx_next = dx_reg; dy_next = dy_reg; adx_next = adx_reg; ady_next = ady_reg;
        t0_next = t0_reg; t1_next = t1_reg; mag_next = mag_reg;
        npx_next = npx_reg; npy_next = npy_reg; nvx_next = nvx_reg; nvy_next = nvy_reg;
        sat_next = sat_reg; moved_next = moved_reg;
        done_next = 1'b0;
        out_next  = out_reg;
        live_raddr = {cx_reg, cy_reg};
        snap_raddr = {nbx, nby};
        live_waddr = {cx_reg, cy_reg};
        snap_waddr = cnt_reg[CW-1:0];
        live_we = 1'b0; snap_we = 1'b0;
        lm_wd = '0; lx_wd = '0; ly_wd = '0;
        sm_wd = lm_rd; sx_wd = lx_rd; sy_wd = ly_rd;
        div_req = '0;
        mul_a = '0; mul_b = '0;
        msum = '0; asum = '0; masum = '0;
        tmpa = '0; tmpb = '0; tmpv = '0;
        mpx = {32'd0, item_reg.pos_x} * {32'd0, item_reg.mass};
        mpy = {32'd0, item_reg.pos_y} * {32'd0, item_reg.mass};

        case (state_reg)
            ST_CLEAR:
            begin
                live_we = 1'b1; snap_we = 1'b1;
                live_waddr = cnt_reg[CW-1:0];
                sm_wd = '0; sx_wd = '0; sy_wd = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[CW-1:0] == {CW{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = in_item;
                    sat_next = 1'b0; moved_next = 1'b0;
                    ax_next = '0; ay_next = '0;
                    nb_next = '0; cnt_next = '0;
                    sub_phase_next = 1'b0;
                    state_next = ST_CELL;
                end
            end
            ST_CELL:
            begin
                cx_next = cell_of(item_reg.pos_x, side);
                cy_next = cell_of(item_reg.pos_y, side);
                case (item_reg.command)
                    pgg_pkg::CMD_DEPOSIT:
                    begin
                        npx_next = item_reg.pos_x; npy_next = item_reg.pos_y;
                        nvx_next = item_reg.vel_x; nvy_next = item_reg.vel_y;
                        state_next = ST_RMW_RD;
                    end
                    pgg_pkg::CMD_ADVANCE: state_next = ST_NB_RD;
                    pgg_pkg::CMD_COMMIT:
                    begin
                        live_raddr = '0;
                        state_next = ST_COPY;
                    end
                    default:
                    begin
                        out_next = '0;
                        done_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_COPY:
            begin
                // read address runs one ahead of the write address
                live_raddr = CW'(cnt_reg + 1'b1);
                if (cnt_reg != '0 || sub_phase_reg)
                begin
                    snap_we = 1'b1;
                    snap_waddr = CW'(cnt_reg - 1'b1);
                end
                if (!sub_phase_reg)
                begin
                    sub_phase_next = 1'b1;
                    live_raddr = CW'(cnt_reg);
                end
                else
                begin
                    snap_waddr = cnt_reg[CW-1:0];
                    live_raddr = CW'(cnt_reg + 1'b1);
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[CW-1:0] == {CW{1'b1}})
                    begin
                        out_next = '0;
                        done_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RMW_RD:
            begin
                // sub_phase 0: touch cell (cx,cy); 1: new cell (nx,ny)
                live_raddr = sub_phase_reg ? {nx_reg, ny_reg} : {cx_reg, cy_reg};
                state_next = ST_RMW_WAIT;
            end
            ST_RMW_WAIT:
            begin
                live_raddr = sub_phase_reg ? {nx_reg, ny_reg} : {cx_reg, cy_reg};
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                live_we = 1'b1;
                if (item_reg.command == pgg_pkg::CMD_ADVANCE && !sub_phase_reg)
                begin
                    live_waddr = {cx_reg, cy_reg};
                    if ({16'd0, item_reg.mass} > lm_rd)
                    begin
                        lm_wd = '0; sat_next = 1'b1;
                    end
                    else
                        lm_wd = lm_rd - {16'd0, item_reg.mass};
                    if (mpx > lx_rd)
                    begin
                        lx_wd = '0; sat_next = 1'b1;
                    end
                    else
                        lx_wd = lx_rd - mpx;
                    if (mpy > ly_rd)
                    begin
                        ly_wd = '0; sat_next = 1'b1;
                    end
                    else
                        ly_wd = ly_rd - mpy;
                    sub_phase_next = 1'b1;
                    state_next = ST_RMW_RD;
                end
                else
                begin
                    live_waddr = sub_phase_reg ? {nx_reg, ny_reg} : {cx_reg, cy_reg};
                    mul_a = {32'd0, item_reg.mass};
                    masum = {1'b0, lm_rd} + {17'd0, item_reg.mass};
                    if (masum[pgg_pkg::MASS_W])
                    begin
                        lm_wd = '1; sat_next = 1'b1;
                    end
                    else
                        lm_wd = masum[pgg_pkg::MASS_W-1:0];
                    msum = sub_phase_reg ? {32'd0, npx_reg} * {32'd0, item_reg.mass} : mpx;
                    asum = {1'b0, lx_rd} + {1'b0, msum};
                    if (asum[64])
                    begin
                        lx_wd = '1; sat_next = 1'b1;
                    end
                    else
                        lx_wd = asum[63:0];
                    msum = sub_phase_reg ? {32'd0, npy_reg} * {32'd0, item_reg.mass} : mpy;
                    asum = {1'b0, ly_rd} + {1'b0, msum};
                    if (asum[64])
                    begin
                        ly_wd = '1; sat_next = 1'b1;
                    end
                    else
                        ly_wd = asum[63:0];
                    state_next = ST_DONE;
                end
            end
            ST_NB_RD:
                state_next = ST_NB_WAIT;
            ST_NB_WAIT:
            begin
                cm_next = sm_rd; csx_next = sx_rd; csy_next = sy_rd;
                if (sm_rd == '0)
                    state_next = ST_DIVW;
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num = sx_rd;
                    div_req.den = {16'd0, sm_rd};
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (div_rsp.done)
                begin
                    t0_next = (div_rsp.quot[63:32] != '0) ? 64'hFFFF_FFFF : div_rsp.quot;
                    div_req.start = 1'b1;
                    div_req.num = csy_reg;
                    div_req.den = {16'd0, cm_reg};
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_rsp.done)
                begin
                    t1_next = (div_rsp.quot[63:32] != '0) ? 64'hFFFF_FFFF : div_rsp.quot;
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                dx_next = $signed({2'b00, t0_reg[31:0]}) - $signed({2'b00, item_reg.pos_x});
                dy_next = $signed({2'b00, t1_reg[31:0]}) - $signed({2'b00, item_reg.pos_y});
                adx_next = dx_next[33] ? 32'(-dx_next) : dx_next[31:0];
                ady_next = dy_next[33] ? 32'(-dy_next) : dy_next[31:0];
                state_next = ST_D2;
                sub_phase_next = 1'b0;
            end
            ST_D2:
            begin
                mul_a = sub_phase_reg ? {32'd0, ady_reg} : {32'd0, adx_reg};
                mul_b = mul_a;
                if (!sub_phase_reg)
                begin
                    t0_next = {32'd0, mul_p[63:32]};
                    sub_phase_next = 1'b1;
                end
                else
                begin
                    t0_next = t0_reg + {32'd0, mul_p[63:32]};
                    sub_phase_next = 1'b0;
                    state_next = ST_MG0;
                end
            end
            ST_MG0:
            begin
                if (t0_reg == '0 || t0_reg < {32'd0, mind_reg})
                    state_next = ST_DIVW;
                else
                begin
                    mul_a = {48'd0, cm_reg[47:32]};
                    mul_b = {32'd0, grav_reg};
                    t1_next = mul_p;
                    state_next = ST_MG1;
                end
            end
            ST_MG1:
            begin
                mul_a = {32'd0, cm_reg[31:0]};
                mul_b = {32'd0, grav_reg};
                msum = t1_reg + {32'd0, mul_p[63:32]};
                div_req.start = 1'b1;
                div_req.num = {msum[47:0], 16'd0};
                div_req.den = t0_reg;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                if (div_rsp.done)
                begin
                    mag_next = div_rsp.quot;
                    state_next = ST_FX0;
                end
            end
            ST_FX0, ST_FY0:
            begin
                mul_a = {32'd0, (state_reg == ST_FX0) ? adx_reg : ady_reg};
                mul_b = {32'd0, mag_reg[63:32]};
                t1_next = mul_p;
                state_next = (state_reg == ST_FX0) ? ST_FX1 : ST_FY1;
            end
            ST_FX1, ST_FY1:
            begin
                mul_a = {32'd0, (state_reg == ST_FX1) ? adx_reg : ady_reg};
                mul_b = {32'd0, mag_reg[31:0]};
                msum = t1_reg + {32'd0, mul_p[63:32]};
                tmpa = $signed({16'd0, msum[63:16]});
                if (state_reg == ST_FX1)
                begin
                    ax_next = dx_reg[33] ? ax_reg - tmpa : ax_reg + tmpa;
                    state_next = ST_FY0;
                end
                else
                begin
                    ay_next = dy_reg[33] ? ay_reg - tmpa : ay_reg + tmpa;
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (nb_reg == 4'd8)
                    state_next = ST_UPD0;
                else
                begin
                    nb_next = nb_reg + 4'd1;
                    state_next = ST_NB_RD;
                end
            end
            ST_UPD0:
            begin
                tmpa = clamp31(ax_reg);
                tmpb = clamp31(ay_reg);
                if (tmpa != ax_reg || tmpb != ay_reg)
                    sat_next = 1'b1;
                ax_next = tmpa; ay_next = tmpb;
                state_next = ST_UPD1;
            end
            ST_UPD1:
            begin
                tmpa = 64'(item_reg.vel_x) + ax_reg;
                tmpb = 64'(item_reg.vel_y) + ay_reg;
                tmpv = clamp31(tmpa);
                if (tmpv != tmpa) sat_next = 1'b1;
                nvx_next = tmpv[31:0];
                npx_next = item_reg.pos_x + 32'(2 * tmpv + ax_reg);
                tmpv = clamp31(tmpb);
                if (tmpv != tmpb) sat_next = 1'b1;
                nvy_next = tmpv[31:0];
                npy_next = item_reg.pos_y + 32'(2 * tmpv + ay_reg);
                state_next = ST_UPD2;
            end
            ST_UPD2:
            begin
                nx_next = cell_of(npx_reg, side);
                ny_next = cell_of(npy_reg, side);
                if (nx_next != cx_reg || ny_next != cy_reg)
                begin
                    moved_next = 1'b1;
                    sub_phase_next = 1'b0;
                    state_next = ST_RMW_RD;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_next.new_pos_x  = npx_reg;
                out_next.new_pos_y  = npy_reg;
                out_next.new_vel_x  = nvx_reg;
                out_next.new_vel_y  = nvy_reg;
                out_next.cell_moved = moved_reg;
                out_next.saturated  = sat_reg;
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            nb_reg        <= '0;
            sub_phase_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            nb_reg        <= nb_next;
            sub_phase_reg <= sub_phase_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cx_reg <= cx_next; cy_reg <= cy_next; nx_reg <= nx_next; ny_reg <= ny_next;
        ax_reg <= ax_next; ay_reg <= ay_next;
        cm_reg <= cm_next; csx_reg <= csx_next; csy_reg <= csy_next;
        dx_reg <= dx_next; dy_reg <= dy_next; adx_reg <= adx_next; ady_reg <= ady_next;
        t0_reg <= t0_next; t1_reg <= t1_next; mag_reg <= mag_next;
        npx_reg <= npx_next; npy_reg <= npy_next; nvx_reg <= nvx_next; nvy_reg <= nvy_next;
        sat_reg <= sat_next; moved_reg <= moved_next;
        out_reg <= out_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign out_item = out_reg;

    ap_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held");
    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && busy) |=> !(state_reg == ST_CELL && $past(state_reg) != ST_IDLE))
        else $error("item taken while busy");
    ap_nb_range: assert property (@(posedge clk) disable iff (!rst_n)
        nb_reg <= 4'd8)
        else $error("neighbor index out of range");

endmodule

// ===== hw/rtl/pgg_divider.sv =====
// ---------------------------------------------------------------------------
// pgg_divider
// Radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pgg_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  pgg_pkg::div_req_t   req,
    output pgg_pkg::div_rsp_t   rsp
);

    logic        busy_reg;
    logic        busy_next;
    logic [6:0]  count_reg;
    logic [6:0]  count_next;
    logic [63:0] quot_reg;
    logic [63:0] quot_next;
    logic [64:0] rem_reg;
    logic [64:0] rem_next;
    logic [63:0] den_reg;
    logic [63:0] den_next;
    logic        done_reg;
    logic        done_next;
    logic [64:0] trial;

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        done_next  = 1'b0;
        trial      = {rem_reg[63:0], quot_reg[63]};
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = 7'd0;
            quot_next  = req.num;
            rem_next   = 65'd0;
            den_next   = req.den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[62:0], 1'b0};
            end
            count_next = count_reg + 7'd1;
            if (count_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 7'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    ap_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg < 7'd64)
        else $error("divider count overrun");
    ap_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider busy while done");

endmodule

// ===== tb/sv/particle_grid_gravity_step_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// particle_grid_gravity_step_test
// Self-checking bench for the grid gravity step: drives deposit, advance,
// commit and unused commands with random gaps, mirrors both cell grids in a
// predictor and compares every result strobe field by field.
// ---------------------------------------------------------------------------
module particle_grid_gravity_step_test;

    localparam logic [pgg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam bit [63:0] LOW32 = 64'hFFFF_FFFF;
    localparam bit [63:0] MASS_LIMIT = 64'hFFFF_FFFF_FFFF;
    localparam bit [63:0] SUM_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam longint Q31_HI = 64'sd2147483647;
    localparam longint Q31_LO = -64'sd2147483648;

    class gravity_scoreboard;
        bit [6:0]  side_reg = 7'd64;
        bit [31:0] g_reg;
        bit [31:0] min_d2_reg;
        bit [63:0] live_mass[pgg_pkg::CELLS];
        bit [63:0] live_mx[pgg_pkg::CELLS];
        bit [63:0] live_my[pgg_pkg::CELLS];
        bit [63:0] snap_mass[pgg_pkg::CELLS];
        bit [63:0] snap_mx[pgg_pkg::CELLS];
        bit [63:0] snap_my[pgg_pkg::CELLS];
        pgg_pkg::out_item_t expected_q[$];
        int        errors;
        bit        clip;
        longint    acc_x, acc_y;

        function void write_reg(logic [pgg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == pgg_pkg::REG_GRID_SIDE) side_reg = data[6:0];
            else if (idx == pgg_pkg::REG_GRAV_CONST) g_reg = data;
            else if (idx == pgg_pkg::REG_MIN_DIST) min_d2_reg = data;
        endfunction

        function bit [63:0] side();
            if (side_reg < 1) return 1;
            if (side_reg > pgg_pkg::MAX_SIDE) return pgg_pkg::MAX_SIDE;
            return side_reg;
        endfunction

        function bit [63:0] add_clip(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
            if (a > lim || b > lim - a)
            begin
                clip = 1;
                return lim;
            end
            return a + b;
        endfunction

        function bit [63:0] sub_floor(bit [63:0] a, bit [63:0] b);
            if (b > a)
            begin
                clip = 1;
                return 0;
            end
            return a - b;
        endfunction

        function longint clamp_q31(longint v);
            if (v > Q31_HI)
            begin
                clip = 1;
                return Q31_HI;
            end
            if (v < Q31_LO)
            begin
                clip = 1;
                return Q31_LO;
            end
            return v;
        endfunction

        function void cell_gain(int idx, bit [63:0] m, bit [63:0] x, bit [63:0] y);
            live_mass[idx] = add_clip(live_mass[idx], m, MASS_LIMIT);
            live_mx[idx] = add_clip(live_mx[idx], m * x, SUM_LIMIT);
            live_my[idx] = add_clip(live_my[idx], m * y, SUM_LIMIT);
        endfunction

        function void cell_lose(int idx, bit [63:0] m, bit [63:0] x, bit [63:0] y);
            live_mass[idx] = sub_floor(live_mass[idx], m);
            live_mx[idx] = sub_floor(live_mx[idx], m * x);
            live_my[idx] = sub_floor(live_my[idx], m * y);
        endfunction

        // floor(a * b / 2^48) with 64-bit wrap on the partial products
        function bit [63:0] scale48(bit [63:0] a, bit [63:0] b);
            bit [63:0] p1, p0;
            p1 = a * (b >> 32);
            p0 = a * (b & LOW32);
            return (p1 + (p0 >> 32)) >> 16;
        endfunction

        function void cell_pull(int idx, bit [63:0] px, bit [63:0] py);
            bit [63:0] m, cxm, cym, adx, ady, d2, mg, mag;
            longint dx, dy, fx, fy;
            m = snap_mass[idx];
            if (m == 0) return;
            cxm = snap_mx[idx] / m;
            cym = snap_my[idx] / m;
            if (cxm > LOW32) cxm = LOW32;
            if (cym > LOW32) cym = LOW32;
            dx = longint'(cxm) - longint'(px);
            dy = longint'(cym) - longint'(py);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            d2 = ((adx * adx) >> 32) + ((ady * ady) >> 32);
            if (d2 == 0 || d2 < {32'd0, min_d2_reg}) return;
            mg = (m >> 32) * g_reg + (((m & LOW32) * g_reg) >> 32);
            mag = (mg << 16) / d2;
            fx = scale48(adx, mag);
            fy = scale48(ady, mag);
            acc_x += dx < 0 ? -fx : fx;
            acc_y += dy < 0 ? -fy : fy;
        endfunction

        function void note_item(pgg_pkg::in_item_t it);
            pgg_pkg::out_item_t r;
            bit [63:0] s, px, py, cx, cy, nx, ny, npx, npy, m;
            bit [63:0] xs[3], ys[3];
            longint vx, vy, nvx, nvy, t;
            s = side();
            px = it.pos_x;
            py = it.pos_y;
            m = it.mass;
            vx = it.vel_x;
            vy = it.vel_y;
            cx = (px * s) >> 32;
            cy = (py * s) >> 32;
            clip = 0;
            r = '0;
            if (it.command == pgg_pkg::CMD_DEPOSIT)
            begin
                cell_gain(int'(cx * pgg_pkg::MAX_SIDE + cy), m, px, py);
                r.new_pos_x = it.pos_x;
                r.new_pos_y = it.pos_y;
                r.new_vel_x = it.vel_x;
                r.new_vel_y = it.vel_y;
                r.saturated = clip;
            end
            else if (it.command == pgg_pkg::CMD_ADVANCE)
            begin
                xs[0] = cx; xs[1] = (cx + 1) % s; xs[2] = (cx + s - 1) % s;
                ys[0] = cy; ys[1] = (cy + 1) % s; ys[2] = (cy + s - 1) % s;
                acc_x = 0;
                acc_y = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        cell_pull(int'(xs[i] * pgg_pkg::MAX_SIDE + ys[j]), px, py);
                acc_x = clamp_q31(acc_x);
                acc_y = clamp_q31(acc_y);
                nvx = clamp_q31(vx + acc_x);
                nvy = clamp_q31(vy + acc_y);
                t = 2 * nvx + acc_x;
                npx = (px + t) & LOW32;
                t = 2 * nvy + acc_y;
                npy = (py + t) & LOW32;
                nx = (npx * s) >> 32;
                ny = (npy * s) >> 32;
                if (nx != cx || ny != cy)
                begin
                    cell_lose(int'(cx * pgg_pkg::MAX_SIDE + cy), m, px, py);
                    cell_gain(int'(nx * pgg_pkg::MAX_SIDE + ny), m, npx, npy);
                    r.cell_moved = 1;
                end
                r.new_pos_x = npx[31:0];
                r.new_pos_y = npy[31:0];
                r.new_vel_x = nvx[31:0];
                r.new_vel_y = nvy[31:0];
                r.saturated = clip;
            end
            else if (it.command == pgg_pkg::CMD_COMMIT)
            begin
                snap_mass = live_mass;
                snap_mx = live_mx;
                snap_my = live_my;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(pgg_pkg::out_item_t got);
            pgg_pkg::out_item_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.new_pos_x !== e.new_pos_x)
                $display("%0t: new_pos_x exp %h got %h", $time, e.new_pos_x, got.new_pos_x);
            if (got.new_pos_y !== e.new_pos_y)
                $display("%0t: new_pos_y exp %h got %h", $time, e.new_pos_y, got.new_pos_y);
            if (got.new_vel_x !== e.new_vel_x)
                $display("%0t: new_vel_x exp %h got %h", $time, e.new_vel_x, got.new_vel_x);
            if (got.new_vel_y !== e.new_vel_y)
                $display("%0t: new_vel_y exp %h got %h", $time, e.new_vel_y, got.new_vel_y);
            if (got.cell_moved !== e.cell_moved)
                $display("%0t: cell_moved exp %b got %b", $time, e.cell_moved, got.cell_moved);
            if (got.saturated !== e.saturated)
                $display("%0t: saturated exp %b got %b", $time, e.saturated, got.saturated);
            if (got !== e) errors++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    pgg_pkg::in_item_t  in_item;
    logic               done;
    pgg_pkg::out_item_t out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    gravity_scoreboard sb;
    bit              no_gaps;
    bit [31:0]       region_x, region_y;

    particle_grid_gravity_step u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .done      (done),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(out_item);
    end

    function int gap_len();
        if (no_gaps) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // one command transfer, then an optional gap with start low
    task send(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
              logic [31:0] vx, logic [31:0] vy, logic [31:0] m);
        pgg_pkg::in_item_t it;
        int       gap;
        it = '{cmd, px, py, vx, vy, m};
        start <= 1;
        in_item <= it;
        do @(posedge clk); while (busy);
        sb.note_item(it);
        gap = gap_len();
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task write_reg(logic [1:0] idx, logic [31:0] data);
        start <= 0;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task drain();
        start <= 0;
        @(posedge clk);
        while (sb.expected_q.size() != 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function logic [31:0] near_pos(logic [31:0] base);
        return base + $urandom_range(0, 32'h0FFF_FFFF);
    endfunction

    function logic [31:0] rand_vel();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 9) < 8) v = $signed(v) >>> $urandom_range(18, 30);
        return v;
    endfunction

    function logic [31:0] rand_mass();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom_range(1, 32'h00FF_FFFF);
        endcase
    endfunction

    task random_item();
        int pick;
        logic [1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = pgg_pkg::CMD_DEPOSIT;
        else if (pick < 93) cmd = pgg_pkg::CMD_ADVANCE;
        else if (pick < 97) cmd = pgg_pkg::CMD_COMMIT;
        else cmd = CMD_UNUSED;
        if ($urandom_range(0, 9) == 0)
            send(cmd, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send(cmd, near_pos(region_x), near_pos(region_y), rand_vel(), rand_vel(),
                 rand_mass());
    endtask

    initial
    begin
        logic [31:0] sides[7];
        logic [31:0] gravs[7];
        logic [31:0] dists[7];
        sb = new();
        rst_n = 0;
        start = 0;
        in_item = '0;
        cfg_valid = 0;
        cfg_index = pgg_pkg::REG_GRID_SIDE;
        cfg_data = 0;
        no_gaps = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: echo extremes, unused command, sum clipping, subtract floor
        send(pgg_pkg::CMD_DEPOSIT, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send(pgg_pkg::CMD_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'hFFFF_FFFF);
        send(pgg_pkg::CMD_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
        send(CMD_UNUSED, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
        send(pgg_pkg::CMD_DEPOSIT, 32'h4000_0000, 32'h4000_0000, 32'h1, 32'h1,
             32'h0100_0000);
        send(pgg_pkg::CMD_DEPOSIT, 32'h4200_0000, 32'h4100_0000, 32'h1, 32'h1,
             32'h0300_0000);
        send(pgg_pkg::CMD_COMMIT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send(pgg_pkg::CMD_ADVANCE, 32'h4100_0000, 32'h4080_0000, 32'h0, 32'h0,
             32'h0100_0000);
        send(pgg_pkg::CMD_ADVANCE, 32'h1000_0000, 32'h1000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h5);
        drain();
        write_reg(pgg_pkg::REG_GRAV_CONST, 32'hFFFF_FFFF);
        write_reg(pgg_pkg::REG_MIN_DIST, 32'h0);
        send(pgg_pkg::CMD_ADVANCE, 32'h4100_0000, 32'h4080_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h0100_0000);
        send(pgg_pkg::CMD_ADVANCE, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'h7FFF_0000,
             32'h7FFF_0000, 32'hFFFF_FFFF);
        send(pgg_pkg::CMD_ADVANCE, 32'h3F00_0000, 32'h4200_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7);
        drain();

        sides = '{32'd64, 32'd1, 32'd2, 32'd3, 32'd127, 32'd0, 32'd17};
        gravs = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0100_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h8000_0000};
        dists = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0010_0000, 32'h0,
                  32'h8000_0000};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(pgg_pkg::REG_GRID_SIDE, ph < 7 ? sides[ph] : $urandom_range(0, 127));
            write_reg(pgg_pkg::REG_GRAV_CONST, ph < 7 ? gravs[ph] : $urandom);
            write_reg(pgg_pkg::REG_MIN_DIST,
                      ph < 7 ? dists[ph] : $urandom_range(0, 32'h00FF_FFFF));
            no_gaps = (ph % 3 == 2);
            region_x = $urandom;
            region_y = $urandom;
            // seed the region, publish it, then mixed traffic
            repeat (8)
                send(pgg_pkg::CMD_DEPOSIT, near_pos(region_x), near_pos(region_y),
                     rand_vel(), rand_vel(), rand_mass());
            send(pgg_pkg::CMD_COMMIT, $urandom, $urandom, $urandom, $urandom, $urandom);
            repeat (90) random_item();
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
